// ===== hw/rtl/lbfc_pkg.sv =====
package lbfc_pkg;

	// One LED entry as it travels around the ring
	typedef struct packed {
		logic [23:0] colour;
		logic        blink;
		logic        visible;
		logic [15:0] interval;
		logic [31:0] due;
	} entry_t;

	// Table contents after reset or clear: black, not blinking, visible
	localparam entry_t ENTRY_RESET = '{
		colour:   24'd0,
		blink:    1'b0,
		visible:  1'b1,
		interval: 16'd0,
		due:      32'd0
	};

	// Controls for the head update unit during the update pass
	typedef struct packed {
		logic        clear;
		logic        set;
		logic        tick;
		logic [23:0] colour;
		logic        blink;
		logic [15:0] interval;
		logic [31:0] now;
	} upd_ctrl_t;

	typedef enum logic [1:0] {
		OP_SET   = 2'd0,
		OP_TICK  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ARG    = 2'd1;
	localparam logic [1:0] ST_UNINIT = 2'd2;

	localparam logic [7:0] ALL_TARGET = 8'd255;

	localparam logic [3:0] CFG_ACTIVE_LEDS = 4'd0;
	localparam logic [3:0] CFG_MIN_BLINK   = 4'd1;

endpackage

// ===== hw/rtl/led_blink_frame_controller.sv =====
// LED blink frame controller. The LED table lives in a ring of MAX_LEDS cells
// that rotates one place per cycle past a single update unit at its head,
// except while a stalled output holds it during the frame rotation. An
// accepted set, tick or clear item takes one full rotation to update the
// table, then a second rotation to send the frame, one pixel per LED in use
// in index order; the next input transfer waits until both rotations are
// done. A tick that toggles nothing skips the frame rotation. Errors (bad
// target, short interval, not initialized) give one status result in the
// cycle after the transfer; a clear on an uninitialized block gives the
// status result while the ring is still being cleared. A new item is taken
// only when the ring is idle. Configuration writes are always ready and must
// only be issued while the block is idle; an LED count above MAX_LEDS acts
// as MAX_LEDS.
module led_blink_frame_controller #(
	parameter int MAX_LEDS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// item input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [7:0]  target,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic        blink_on,
	input  logic [15:0] blink_period,
	input  logic [31:0] now_ms,
	// result output
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        pixel_valid,
	output logic [5:0]  led_index,
	output logic [7:0]  pixel_red,
	output logic [7:0]  pixel_green,
	output logic [7:0]  pixel_blue,
	output logic        last,
	// configuration write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import lbfc_pkg::*;

	localparam int CNT_W = $clog2(MAX_LEDS + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_UPDATE,
		S_EMIT
	} state_t;

	state_t      state_q;
	logic [CNT_W-1:0] cnt_q;
	op_t         op_q;
	logic [7:0]  target_q;
	logic [23:0] colour_q;
	logic        blink_q;
	logic [15:0] interval_q;
	logic [31:0] now_q;
	logic        changed_q;

	logic [5:0]  active_leds_q;
	logic [15:0] min_blink_q;

	logic        out_valid_q;
	logic [1:0]  status_q;
	logic        pixel_valid_q;
	logic [5:0]  led_index_q;
	logic [23:0] pixel_q;
	logic        last_q;

	entry_t      ring [MAX_LEDS];
	entry_t      head_upd;
	upd_ctrl_t   ctrl;
	logic        toggled;
	logic        shift_en;
	logic        out_free;
	logic        in_xfer;
	logic [CNT_W-1:0] n;
	logic        in_use;
	logic        cnt_end;
	logic        emit_px;
	logic        head_dark;
	logic        bad_target;
	logic        short_int;
	logic        st_load;
	logic [1:0]  st_code;

	// LEDs in use, clamped to the ring size
	assign n = ({1'b0, active_leds_q} > 7'(MAX_LEDS)) ? CNT_W'(MAX_LEDS)
		: CNT_W'(active_leds_q);

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || !out_free;
	assign in_xfer  = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign in_use  = cnt_q < n;
	assign cnt_end = cnt_q == CNT_W'(MAX_LEDS - 1);
	assign emit_px = (state_q == S_EMIT) && out_free && in_use;
	assign shift_en = (state_q == S_UPDATE) || ((state_q == S_EMIT) && out_free);

	assign bad_target = (target != ALL_TARGET) && (target >= 8'(n));
	assign short_int  = blink_on && (blink_period < min_blink_q);

	// Single status result for errors and uninitialized cases
	always_comb begin
		st_load = 1'b0;
		st_code = ST_OK;
		if (in_xfer) begin
			unique case (op_t'(op))
				OP_SET: begin
					if (n == '0) begin
						st_load = 1'b1;
						st_code = ST_UNINIT;
					end else if (bad_target || short_int) begin
						st_load = 1'b1;
						st_code = ST_ARG;
					end
				end
				OP_CLEAR: begin
					if (n == '0) begin
						st_load = 1'b1;
						st_code = ST_UNINIT;
					end
				end
				default: ;
			endcase
		end
	end

	// Head update controls for the entry now at position zero
	always_comb begin
		ctrl.clear    = (state_q == S_UPDATE) && (op_q == OP_CLEAR);
		ctrl.set      = (state_q == S_UPDATE) && (op_q == OP_SET) && in_use
			&& ((target_q == ALL_TARGET) || (target_q == 8'(cnt_q)));
		ctrl.tick     = (state_q == S_UPDATE) && (op_q == OP_TICK) && in_use;
		ctrl.colour   = colour_q;
		ctrl.blink    = blink_q;
		ctrl.interval = interval_q;
		ctrl.now      = now_q;
	end

	lbfc_update u_update (
		.ctrl    (ctrl),
		.d       (ring[0]),
		.q       (head_upd),
		.toggled (toggled)
	);

	// Ring of cells: each takes its upper neighbor, the top takes the head update
	for (genvar k = 0; k < MAX_LEDS; k++) begin : g_cell
		entry_t cell_d;
		if (k == MAX_LEDS - 1) begin : g_top
			assign cell_d = head_upd;
		end else begin : g_mid
			assign cell_d = ring[k + 1];
		end
		lbfc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (shift_en),
			.d        (cell_d),
			.q        (ring[k])
		);
	end

	assign head_dark = ring[0].blink && !ring[0].visible;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_leds_q <= 6'd0;
			min_blink_q   <= 16'd50;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ACTIVE_LEDS: active_leds_q <= cfg_data[5:0];
				CFG_MIN_BLINK:   min_blink_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer with item and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			changed_q     <= 1'b0;
			out_valid_q   <= 1'b0;
			op_q          <= OP_NONE;
			target_q      <= 8'd0;
			colour_q      <= 24'd0;
			blink_q       <= 1'b0;
			interval_q    <= 16'd0;
			now_q         <= 32'd0;
			status_q      <= ST_OK;
			pixel_valid_q <= 1'b0;
			led_index_q   <= 6'd0;
			pixel_q       <= 24'd0;
			last_q        <= 1'b0;
		end else begin
			// a result is loaded or a stalled one is held
			out_valid_q <= st_load || emit_px || (out_valid_q && out_stall);
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						op_q       <= op_t'(op);
						target_q   <= target;
						colour_q   <= {red, green, blue};
						blink_q    <= blink_on;
						interval_q <= blink_period;
						now_q      <= now_ms;
						changed_q  <= 1'b0;
						cnt_q      <= '0;
						status_q      <= st_code;
						pixel_valid_q <= 1'b0;
						led_index_q   <= 6'd0;
						pixel_q       <= 24'd0;
						last_q        <= 1'b1;
						unique case (op_t'(op))
							OP_SET: begin
								if (!st_load) begin
									state_q <= S_UPDATE;
								end
							end
							OP_TICK: begin
								if (n != '0) begin
									state_q <= S_UPDATE;
								end
							end
							OP_CLEAR: begin
								state_q <= S_UPDATE;
							end
							default: ;
						endcase
					end
				end
				S_UPDATE: begin
					if (toggled) begin
						changed_q <= 1'b1;
					end
					if (cnt_end) begin
						cnt_q <= '0;
						if (op_q == OP_TICK && !(changed_q || toggled)) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_EMIT;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_EMIT: begin
					if (emit_px) begin
						status_q      <= ST_OK;
						pixel_valid_q <= 1'b1;
						led_index_q   <= 6'(cnt_q);
						pixel_q       <= head_dark ? 24'd0 : ring[0].colour;
						last_q        <= (cnt_q + 1'b1) == n;
					end
					if (out_free) begin
						if (cnt_end) begin
							cnt_q   <= '0;
							state_q <= S_IDLE;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign pixel_valid = pixel_valid_q;
	assign led_index   = led_index_q;
	assign pixel_red   = pixel_q[23:16];
	assign pixel_green = pixel_q[15:8];
	assign pixel_blue  = pixel_q[7:0];
	assign last        = last_q;

endmodule

// ===== hw/rtl/lbfc_cell.sv =====
module lbfc_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift_en,
	input  lbfc_pkg::entry_t d,
	output lbfc_pkg::entry_t q
);
	import lbfc_pkg::*;

	entry_t entry_q;

	// Holds one LED entry; takes the neighbor's entry on each ring step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= ENTRY_RESET;
		end else if (shift_en) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule

// ===== hw/rtl/lbfc_update.sv =====
module lbfc_update (
	input  lbfc_pkg::upd_ctrl_t ctrl,
	input  lbfc_pkg::entry_t    d,
	output lbfc_pkg::entry_t    q,
	output logic                toggled
);
	import lbfc_pkg::*;

	logic [31:0] since_due;
	logic [31:0] next_due;
	logic        due;

	// Wrap-safe due test: now minus due time is non-negative
	assign since_due = ctrl.now - d.due;
	assign next_due  = ctrl.now + {16'd0, ctrl.set ? ctrl.interval : d.interval};
	assign due       = d.blink && !since_due[31];

	always_comb begin
		q       = d;
		toggled = 1'b0;
		if (ctrl.clear) begin
			q = ENTRY_RESET;
		end else if (ctrl.set) begin
			q.colour   = ctrl.colour;
			q.blink    = ctrl.blink;
			q.visible  = 1'b1;
			q.interval = ctrl.blink ? ctrl.interval : 16'd0;
			q.due      = ctrl.blink ? next_due : 32'd0;
		end else if (ctrl.tick && due) begin
			q.visible = !d.visible;
			q.due     = next_due;
			toggled   = 1'b1;
		end
	end

endmodule

// ===== test/tb_led_blink_frame_controller.sv =====
`timescale 1ns / 1ps

module tb_led_blink_frame_controller;
	import lbfc_pkg::*;

	localparam int MAX_LEDS    = 32;
	// ring rotations plus margin: covers items that leave no result behind
	localparam int SETTLE      = 3 * MAX_LEDS + 16;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_ITEMS  = 42;

	// One command item as sent to the block
	typedef struct {
		op_t         op;
		logic [7:0]  target;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        blink;
		logic [15:0] interval;
		logic [31:0] now;
	} led_cmd_t;

	// One result as seen on the output channel
	typedef struct {
		logic [1:0] status;
		logic       pixel_valid;
		logic [5:0] led_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} pixel_t;

	logic        clk;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_stall;
	logic [1:0]  op           = 2'd0;
	logic [7:0]  target       = 8'd0;
	logic [7:0]  red          = 8'd0;
	logic [7:0]  green        = 8'd0;
	logic [7:0]  blue         = 8'd0;
	logic        blink_on     = 1'b0;
	logic [15:0] blink_period = 16'd0;
	logic [31:0] now_ms       = 32'd0;
	logic        out_valid;
	logic        out_stall    = 1'b0;
	logic [1:0]  status;
	logic        pixel_valid;
	logic [5:0]  led_index;
	logic [7:0]  pixel_red;
	logic [7:0]  pixel_green;
	logic [7:0]  pixel_blue;
	logic        last;
	logic        cfg_valid    = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_index    = 4'd0;
	logic [15:0] cfg_data     = 16'd0;

	// Shadow copy of the LED table and registers
	logic [23:0] colour_mem [MAX_LEDS];
	logic        blink_mem  [MAX_LEDS];
	logic        lit_mem    [MAX_LEDS];
	logic [15:0] period_mem [MAX_LEDS];
	logic [31:0] due_mem    [MAX_LEDS];
	logic [5:0]  active_leds_q = 6'd0;
	logic [15:0] min_period_q  = 16'd50;
	pixel_t      expected_pixels [$];

	int          mismatches    = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	logic        hold_req      = 1'b0;
	logic [31:0] clock_ms      = 32'd0;
	int          cycle_cnt     = 0;

	led_blink_frame_controller #(
		.MAX_LEDS(MAX_LEDS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.target(target),
		.red(red),
		.green(green),
		.blue(blue),
		.blink_on(blink_on),
		.blink_period(blink_period),
		.now_ms(now_ms),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.pixel_valid(pixel_valid),
		.led_index(led_index),
		.pixel_red(pixel_red),
		.pixel_green(pixel_green),
		.pixel_blue(pixel_blue),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("tb: failure");
		$finish;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	task automatic clear_table();
		for (int i = 0; i < MAX_LEDS; i++) begin
			colour_mem[i] = 24'd0;
			blink_mem[i]  = 1'b0;
			lit_mem[i]    = 1'b1;
			period_mem[i] = 16'd0;
			due_mem[i]    = 32'd0;
		end
	endtask

	// an LED count above the table size acts as the table size
	function automatic int lights_in_use();
		return (int'(active_leds_q) > MAX_LEDS) ? MAX_LEDS : int'(active_leds_q);
	endfunction

	task automatic push_status(input logic [1:0] st);
		pixel_t px;
		px.status      = st;
		px.pixel_valid = 1'b0;
		px.led_index   = 6'd0;
		px.red         = 8'd0;
		px.green       = 8'd0;
		px.blue        = 8'd0;
		px.last        = 1'b1;
		expected_pixels.push_back(px);
	endtask

	// One pixel per LED in use; blinking LEDs in the off phase show black
	task automatic push_frame();
		pixel_t px;
		int     n;
		logic   dark;
		n = lights_in_use();
		for (int i = 0; i < n; i++) begin
			dark           = blink_mem[i] && !lit_mem[i];
			px.status      = ST_OK;
			px.pixel_valid = 1'b1;
			px.led_index   = 6'(i);
			px.red         = dark ? 8'd0 : colour_mem[i][23:16];
			px.green       = dark ? 8'd0 : colour_mem[i][15:8];
			px.blue        = dark ? 8'd0 : colour_mem[i][7:0];
			px.last        = (i == n - 1);
			expected_pixels.push_back(px);
		end
	endtask

	task automatic predict_frame(input led_cmd_t c);
		int          n;
		logic        changed;
		logic [31:0] lag;
		n = lights_in_use();
		changed = 1'b0;
		case (c.op)
			OP_SET: begin
				if (n == 0)
					push_status(ST_UNINIT);
				else if (c.target != ALL_TARGET && int'(c.target) >= n)
					push_status(ST_ARG);
				else if (c.blink && c.interval < min_period_q)
					push_status(ST_ARG);
				else begin
					for (int i = 0; i < n; i++) begin
						if (c.target == ALL_TARGET || int'(c.target) == i) begin
							colour_mem[i] = {c.red, c.green, c.blue};
							blink_mem[i]  = c.blink;
							lit_mem[i]    = 1'b1;
							period_mem[i] = c.blink ? c.interval : 16'd0;
							due_mem[i]    = c.blink ? c.now + 32'(c.interval) : 32'd0;
						end
					end
					push_frame();
				end
			end
			OP_TICK: begin
				// due when now - due, taken mod 2^32, is below 2^31
				for (int i = 0; i < n; i++) begin
					lag = c.now - due_mem[i];
					if (blink_mem[i] && !lag[31]) begin
						lit_mem[i] = !lit_mem[i];
						due_mem[i] = c.now + 32'(period_mem[i]);
						changed    = 1'b1;
					end
				end
				if (changed)
					push_frame();
			end
			OP_CLEAR: begin
				clear_table();
				if (n == 0)
					push_status(ST_UNINIT);
				else
					push_frame();
			end
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// Driving
	// ------------------------------------------------------------------

	function automatic led_cmd_t make_cmd(input op_t o, input logic [7:0] tgt,
			input logic [23:0] rgb, input logic blink, input logic [15:0] ivl,
			input logic [31:0] now);
		led_cmd_t c;
		c.op       = o;
		c.target   = tgt;
		c.red      = rgb[23:16];
		c.green    = rgb[15:8];
		c.blue     = rgb[7:0];
		c.blink    = blink;
		c.interval = ivl;
		c.now      = now;
		return c;
	endfunction

	// Offer one item and hold it until the transfer
	task automatic send_cmd(input led_cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		op           <= c.op;
		target       <= c.target;
		red          <= c.red;
		green        <= c.green;
		blue         <= c.blue;
		blink_on     <= c.blink;
		blink_period <= c.interval;
		now_ms       <= c.now;
		do @(posedge clk); while (in_stall);
		predict_frame(c);
	endtask

	// Drain all results, then give the ring time to finish silent items
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Both registers back to back, valid held high between the transfers
	task automatic write_regs(input logic [5:0] count, input logic [15:0] min_period);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_ACTIVE_LEDS;
		cfg_data  <= {10'd0, count};
		do @(posedge clk); while (!cfg_ready);
		active_leds_q = count;
		cfg_index <= CFG_MIN_BLINK;
		cfg_data  <= min_period;
		do @(posedge clk); while (!cfg_ready);
		min_period_q = min_period;
		cfg_valid <= 1'b0;
	endtask

	// Mostly ticks and legal sets on a running clock, some clears, some junk
	function automatic led_cmd_t random_cmd();
		led_cmd_t c;
		int       pick;
		int       n;
		int       ivl;
		pick = $urandom_range(99);
		n = lights_in_use();
		c = make_cmd(OP_TICK, 8'd0, 24'($urandom), 1'b0, 16'd0, 32'd0);
		if (pick < 45) begin
			clock_ms += 32'($urandom_range(1, 40));
			c.now = clock_ms;
		end else if (pick < 77) begin
			c.op     = OP_SET;
			c.target = ($urandom_range(9) == 0) ? ALL_TARGET : 8'($urandom_range(0, n - 1));
			c.blink  = ($urandom_range(3) != 0);
			ivl      = int'(min_period_q) + $urandom_range(0, 80);
			c.interval = c.blink ? 16'((ivl > 65535) ? 65535 : ivl) : 16'($urandom);
			clock_ms += 32'($urandom_range(0, 5));
			c.now = clock_ms;
		end else if (pick < 82) begin
			c.op = OP_CLEAR;
		end else begin
			c.op       = op_t'($urandom_range(0, 3));
			c.target   = 8'($urandom);
			c.blink    = 1'($urandom);
			c.interval = 16'($urandom);
			c.now      = $urandom;
		end
		return c;
	endfunction

	// ------------------------------------------------------------------
	// Output side
	// ------------------------------------------------------------------

	// Receiver stall, with a long hold-off on request
	initial begin : stall_driver
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	task automatic report_error(input string msg);
		mismatches++;
		$display("[%0t] ERROR %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input pixel_t got, input logic [31:0] g,
			input logic [31:0] w);
		if (g !== w)
			report_error($sformatf("%s: got 0x%0h, expected 0x%0h (led %0d)",
				name, g, w, got.led_index));
	endtask

	// Compare each result transfer with the oldest expected pixel
	initial begin : result_checker
		pixel_t got;
		pixel_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got.status      = status;
				got.pixel_valid = pixel_valid;
				got.led_index   = led_index;
				got.red         = pixel_red;
				got.green       = pixel_green;
				got.blue        = pixel_blue;
				got.last        = last;
				// let a transfer on the input side at this edge be predicted first
				#1;
				if (expected_pixels.size() == 0) begin
					report_error($sformatf("result with nothing expected: status %0d led %0d",
						got.status, got.led_index));
				end else begin
					want = expected_pixels.pop_front();
					check_field("status", got, 32'(got.status), 32'(want.status));
					check_field("pixel_valid", got, 32'(got.pixel_valid),
						32'(want.pixel_valid));
					check_field("led_index", got, 32'(got.led_index), 32'(want.led_index));
					check_field("pixel_red", got, 32'(got.red), 32'(want.red));
					check_field("pixel_green", got, 32'(got.green), 32'(want.green));
					check_field("pixel_blue", got, 32'(got.blue), 32'(want.blue));
					check_field("last", got, 32'(got.last), 32'(want.last));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// LED count still zero after reset
	task automatic test_uninitialized();
		send_idle_pct = 11;
		recv_idle_pct = 73;
		send_cmd(make_cmd(OP_SET, 8'd0, 24'h123456, 1'b0, 16'd0, 32'd0));
		send_cmd(make_cmd(OP_TICK, 8'd0, 24'd0, 1'b0, 16'd0, 32'd100));
		send_cmd(make_cmd(OP_CLEAR, 8'd0, 24'd0, 1'b0, 16'd0, 32'd0));
		send_cmd(make_cmd(OP_NONE, 8'd3, 24'hABCDEF, 1'b1, 16'd77, 32'd9));
		send_cmd(make_cmd(OP_SET, ALL_TARGET, 24'hFFFFFF, 1'b1, 16'd100, 32'd0));
		wait_idle();
	endtask

	// Field extremes, argument errors, due compare around wrap and at 2^31
	task automatic test_directed();
		write_regs(6'd32, 16'd50);
		send_cmd(make_cmd(OP_SET, 8'd0, 24'hFFFFFF, 1'b0, 16'd0, 32'd0));
		send_cmd(make_cmd(OP_SET, 8'd31, 24'h123456, 1'b0, 16'd0, 32'd0));
		send_cmd(make_cmd(OP_SET, 8'd32, 24'h654321, 1'b0, 16'd0, 32'd0));
		send_cmd(make_cmd(OP_SET, 8'd254, 24'h654321, 1'b0, 16'd0, 32'd0));
		// blink off keeps no interval
		send_cmd(make_cmd(OP_SET, ALL_TARGET, 24'h804020, 1'b0, 16'hFFFF, 32'hFFFF_FFFF));
		send_cmd(make_cmd(OP_SET, 8'd5, 24'h0000FF, 1'b1, 16'd49, 32'd1000));
		send_cmd(make_cmd(OP_SET, 8'd5, 24'h00FF00, 1'b1, 16'd50, 32'd1000));
		send_cmd(make_cmd(OP_SET, 8'd6, 24'hFF0000, 1'b1, 16'hFFFF, 32'hFFFF_FFF0));
		send_cmd(make_cmd(OP_TICK, 8'd0, 24'd0, 1'b0, 16'd0, 32'd1049));
		send_cmd(make_cmd(OP_TICK, 8'd0, 24'd0, 1'b0, 16'd0, 32'd1050));
		send_cmd(make_cmd(OP_TICK, 8'd0, 24'd0, 1'b0, 16'd0, 32'd1100));
		// LED 6 due time wrapped past zero
		send_cmd(make_cmd(OP_TICK, 8'd0, 24'd0, 1'b0, 16'd0, 32'h0000_FFEF));
		// LED 5 exactly half the range away: not due
		send_cmd(make_cmd(OP_TICK, 8'd0, 24'd0, 1'b0, 16'd0, 32'h8001_0021));
		send_cmd(make_cmd(OP_NONE, 8'd0, 24'd0, 1'b0, 16'd0, 32'd0));
		send_cmd(make_cmd(OP_CLEAR, 8'd0, 24'd0, 1'b0, 16'd0, 32'd0));
		send_cmd(make_cmd(OP_TICK, 8'd0, 24'd0, 1'b0, 16'd0, 32'd5));
		send_cmd(make_cmd(OP_SET, ALL_TARGET, 24'hA5C3E1, 1'b1, 16'd50, 32'd0));
		send_cmd(make_cmd(OP_TICK, 8'd0, 24'd0, 1'b0, 16'd0, 32'd50));
		send_cmd(make_cmd(OP_TICK, 8'd0, 24'd0, 1'b0, 16'd0, 32'd100));
		wait_idle();
	endtask

	// Register extremes: one LED, zero interval, oversized count, max interval
	task automatic test_register_extremes();
		write_regs(6'd1, 16'd0);
		send_cmd(make_cmd(OP_SET, 8'd0, 24'h112233, 1'b1, 16'd0, 32'd7));
		send_cmd(make_cmd(OP_TICK, 8'd0, 24'd0, 1'b0, 16'd0, 32'd7));
		send_cmd(make_cmd(OP_TICK, 8'd0, 24'd0, 1'b0, 16'd0, 32'd7));
		send_cmd(make_cmd(OP_SET, 8'd1, 24'h445566, 1'b0, 16'd0, 32'd0));
		send_cmd(make_cmd(OP_SET, ALL_TARGET, 24'h778899, 1'b0, 16'd0, 32'd0));
		wait_idle();
		write_regs(6'd63, 16'hFFFF);
		send_cmd(make_cmd(OP_SET, 8'd0, 24'h010203, 1'b1, 16'hFFFE, 32'd0));
		send_cmd(make_cmd(OP_SET, 8'd0, 24'h010203, 1'b1, 16'hFFFF, 32'd0));
		send_cmd(make_cmd(OP_SET, 8'd31, 24'hFEDCBA, 1'b0, 16'd0, 32'd0));
		send_cmd(make_cmd(OP_TICK, 8'd0, 24'd0, 1'b0, 16'd0, 32'd65535));
		wait_idle();
		write_regs(6'd40, 16'd200);
		send_cmd(make_cmd(OP_SET, 8'd33, 24'h0F0F0F, 1'b0, 16'd0, 32'd0));
		send_cmd(make_cmd(OP_SET, 8'd31, 24'hF0F0F0, 1'b1, 16'd200, 32'd10));
		wait_idle();
		// back to uninitialized: clear still wipes the table
		write_regs(6'd0, 16'd50);
		send_cmd(make_cmd(OP_CLEAR, 8'd0, 24'd0, 1'b0, 16'd0, 32'd0));
		send_cmd(make_cmd(OP_TICK, 8'd0, 24'd0, 1'b0, 16'd0, 32'd300));
		wait_idle();
		write_regs(6'd4, 16'd50);
		send_cmd(make_cmd(OP_TICK, 8'd0, 24'd0, 1'b0, 16'd0, 32'd400));
		send_cmd(make_cmd(OP_SET, 8'd3, 24'h00AA55, 1'b0, 16'd0, 32'd0));
		wait_idle();
	endtask

	// Receiver holds off while the sender keeps offering; input must back up
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_regs(6'd32, 16'd50);
		clock_ms = 32'd1000;
		hold_req = 1'b1;
		for (int i = 0; i < 8; i++)
			send_cmd(random_cmd());
		wait_idle();
	endtask

	task automatic run_random_phase(input int send_pct, input int recv_pct);
		led_cmd_t c;
		int       sent;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int part = 0; part < 2; part++) begin
			write_regs(6'($urandom_range(1, MAX_LEDS)), 16'($urandom_range(0, 120)));
			clock_ms = $urandom;
			sent = 0;
			while (sent < RAND_ITEMS / 2) begin
				c = random_cmd();
				send_cmd(c);
				if (c.op != OP_NONE)
					sent++;
			end
			wait_idle();
		end
	endtask

	task automatic test_random_traffic();
		run_random_phase(11, 73);
		run_random_phase(73, 11);
		run_random_phase(0, 0);
	endtask

	initial begin
		clear_table();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_uninitialized();
		test_directed();
		test_register_extremes();
		test_backpressure();
		test_random_traffic();
		wait_idle();
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
